// ----- rtl/gpvs_pkg.sv -----
// gait phase valve sequencer: shared types, codes and fixed constants
// no dependencies; imported by the channel interfaces and the top level

package gpvs_pkg;

   // gait period limits and the step divisor of the gait percentage
   localparam int PERIOD_MIN  = 500;
   localparam int PERIOD_MAX  = 2000;
   localparam int STEP_DIV    = 202;

   // field widths
   localparam int PERIOD_IN_W = 16;
   localparam int PERIOD_W    = 11;
   localparam int FP_W        = 7;
   localparam int UNITS_W     = 8;
   localparam int DELAY_W     = 16;
   localparam int OUT_PCT_W   = 7;
   localparam int CMD_W       = 2;
   localparam int PROD_UP_W   = UNITS_W + PERIOD_W;

   // gait step counter: a step is due after at most ten ticks
   localparam int GSTEP_W     = 4;
   localparam int GPROD_W     = GSTEP_W + 8;

   // configuration port
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DELAY_RESET = 50;

   // legs and channels within a leg
   localparam int LEGS        = 2;
   localparam int LEG_CH      = 3;
   localparam int CH_IDX_W    = 2;
   localparam int LEG_LEFT    = 0;
   localparam int LEG_RIGHT   = 1;
   localparam logic [CH_IDX_W-1:0] CH_CALF  = 2'd0;
   localparam logic [CH_IDX_W-1:0] CH_QUAD  = 2'd1;
   localparam logic [CH_IDX_W-1:0] CH_GLUTE = 2'd2;

   // result words held on the output side
   localparam int OUT_SLOTS   = 2;
   localparam int OCC_W       = 2;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd1,
      PH_CONTRACT = 2'd2,
      PH_EXTEND   = 2'd3
   } phase_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_NONE    = 2'd0,
      CMD_FILL    = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CALF_FIRE    = 3'd0,
      CSR_QUAD_FIRE    = 3'd1,
      CSR_GLUTE_FIRE   = 3'd2,
      CSR_CALF_UNITS   = 3'd3,
      CSR_QUAD_UNITS   = 3'd4,
      CSR_GLUTE_UNITS  = 3'd5,
      CSR_EXTEND_DELAY = 3'd6,
      CSR_RIGHT_START  = 3'd7
   } csr_index_type;

   typedef struct packed {
      cmd_type                left_calf;
      cmd_type                left_quad;
      cmd_type                left_glute;
      cmd_type                right_calf;
      cmd_type                right_quad;
      cmd_type                right_glute;
      logic [OUT_PCT_W-1:0]   left_pct;
      logic [OUT_PCT_W-1:0]   right_pct;
   } rsp_word_type;

endpackage

// ----- rtl/gpvs_if.sv -----
// gait phase valve sequencer: valid/ready channel interfaces for tick and result words
// depends on gpvs_pkg for the field widths

interface gpvs_req_if import gpvs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [PERIOD_IN_W-1:0] gait_period_ms;

   modport source (output valid, output gait_period_ms, input ready);
   modport sink   (input valid, input gait_period_ms, output ready);
endinterface

interface gpvs_rsp_if import gpvs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     left_calf_cmd;
   logic [CMD_W-1:0]     left_quad_cmd;
   logic [CMD_W-1:0]     left_glute_cmd;
   logic [CMD_W-1:0]     right_calf_cmd;
   logic [CMD_W-1:0]     right_quad_cmd;
   logic [CMD_W-1:0]     right_glute_cmd;
   logic [OUT_PCT_W-1:0] left_gait_pct;
   logic [OUT_PCT_W-1:0] right_gait_pct;

   modport source (
      output valid, output left_calf_cmd, output left_quad_cmd, output left_glute_cmd,
      output right_calf_cmd, output right_quad_cmd, output right_glute_cmd,
      output left_gait_pct, output right_gait_pct, input ready
   );
   modport sink (
      input valid, input left_calf_cmd, input left_quad_cmd, input left_glute_cmd,
      input right_calf_cmd, input right_quad_cmd, input right_glute_cmd,
      input left_gait_pct, input right_gait_pct, output ready
   );
endinterface

// ----- rtl/gpvs_ram.sv -----
// gait phase valve sequencer: generic single-write, single-read ram with registered read
// no dependencies

module gpvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/gait_phase_valve_sequencer.sv -----
// gait phase valve sequencer top level: six valve channels kept in two leg memories
// depends on gpvs_pkg, gpvs_req_if / gpvs_rsp_if and gpvs_ram
// result word: registered once the tick's glute channel leaves the decide stage
// issue: a tick word waits for the last glute issue and a free output slot; each leg
//   memory is visited once per channel per tick via its one read port, legs in parallel
// reset: synchronous, active high; clears the pipeline, loads config reset values and
//   marks every channel entry invalid so it reads as idle with zero counters (no sweep)

module gait_phase_valve_sequencer import gpvs_pkg::*; #(
   parameter int GAIT_STEPS  = 100,
   parameter int TIMER_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   gpvs_req_if.sink              req_ch,
   gpvs_rsp_if.source            rsp_ch,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int PCT_RAW_W = $clog2(GAIT_STEPS + 1);
   localparam int PCT_W     = (PCT_RAW_W > FP_W) ? PCT_RAW_W : FP_W;
   localparam int EL_PROD_W = TIMER_WIDTH + 8;
   localparam int CMP_W     = (EL_PROD_W > PROD_UP_W) ? EL_PROD_W : PROD_UP_W;

   typedef struct packed {
      phase_type              phase;
      logic                   busy;
      logic                   fired;
      logic                   epoch;
      logic [TIMER_WIDTH-1:0] elapsed;
   } chan_type;

   localparam int CHAN_W = $bits(chan_type);

   localparam chan_type RESET_ENT = '{
      phase: PH_IDLE, busy: 1'b0, fired: 1'b0, epoch: 1'b0, elapsed: '0
   };

   typedef struct packed {
      logic [PERIOD_W-1:0]                period;
      logic [LEGS-1:0][PCT_W-1:0]         pct;
      logic [LEGS-1:0]                    epoch;
      logic [LEGS-1:0][OUT_PCT_W-1:0]     out_pct;
   } tick_type;

   // configuration registers
   logic [FP_W-1:0]    fire_pt_ff [LEG_CH];
   logic [UNITS_W-1:0] units_ff   [LEG_CH];
   logic [DELAY_W-1:0] ext_delay_ff;

   // gait step state
   logic [GSTEP_W-1:0]          gstep_ff, gstep_in, gstep_inc;
   logic                        gstep_due;
   logic [LEGS-1:0][PCT_W-1:0]  pct_ff, pct_in;
   logic [LEGS-1:0][PCT_W:0]    pct_plus;
   logic [LEGS-1:0]             pct_wrap;
   logic [LEGS-1:0]             epoch_ff, epoch_in;
   logic [PERIOD_W-1:0]         period_in;

   // tick context and channel issue
   tick_type                    tick_ff;
   logic                        iss_active_ff, iss_active_in;
   logic [CH_IDX_W-1:0]         iss_idx_ff, iss_idx_in;
   logic                        issue_free;
   logic                        accept;

   // read stage
   logic                        s1_v_ff;
   logic [CH_IDX_W-1:0]         s1_idx_ff;
   tick_type                    s1_tick_ff;
   logic [CHAN_W-1:0]           rd_raw   [LEGS];
   chan_type                    s1_ent   [LEGS];
   logic [CMP_W-1:0]            s1_prod  [LEGS];
   logic [PROD_UP_W-1:0]        s1_up;
   logic [LEGS-1:0][LEG_CH-1:0] vld_ff;

   // decide and write-back stage
   logic                        s2_v_ff;
   logic [CH_IDX_W-1:0]         s2_idx_ff;
   tick_type                    s2_tick_ff;
   chan_type                    s2_ent_ff  [LEGS];
   logic [CMP_W-1:0]            s2_prod_ff [LEGS];
   logic [PROD_UP_W-1:0]        s2_up_ff;
   chan_type                    wr_ent     [LEGS];
   cmd_type                     cmd_w      [LEGS];

   // result assembly and output slots
   cmd_type                     asm_ff [LEGS][LEG_CH];
   logic                        push, pop;
   rsp_word_type                push_word;
   rsp_word_type                out_ff, out_in, skid_ff, skid_in;
   logic                        out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   logic [OCC_W-1:0]            occ_ff, occ_in;

   // handshake
   assign issue_free   = !iss_active_ff || (iss_idx_ff == CH_GLUTE);
   assign pop          = out_v_ff && rsp_ch.ready;
   assign req_ch.ready = issue_free && ((occ_ff < OCC_W'(OUT_SLOTS)) || pop);
   assign accept       = req_ch.valid && req_ch.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         fire_pt_ff   <= '{default: '0};
         units_ff     <= '{default: '0};
         ext_delay_ff <= DELAY_W'(DELAY_RESET);
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_CALF_FIRE:    fire_pt_ff[CH_CALF]  <= csr_write_data[FP_W-1:0];
            CSR_QUAD_FIRE:    fire_pt_ff[CH_QUAD]  <= csr_write_data[FP_W-1:0];
            CSR_GLUTE_FIRE:   fire_pt_ff[CH_GLUTE] <= csr_write_data[FP_W-1:0];
            CSR_CALF_UNITS:   units_ff[CH_CALF]    <= csr_write_data[UNITS_W-1:0];
            CSR_QUAD_UNITS:   units_ff[CH_QUAD]    <= csr_write_data[UNITS_W-1:0];
            CSR_GLUTE_UNITS:  units_ff[CH_GLUTE]   <= csr_write_data[UNITS_W-1:0];
            CSR_EXTEND_DELAY: ext_delay_ff         <= csr_write_data[DELAY_W-1:0];
            default: ;
         endcase
      end
   end

   // period clamp
   always_comb begin
      if (req_ch.gait_period_ms > PERIOD_IN_W'(PERIOD_MAX)) begin
         period_in = PERIOD_W'(PERIOD_MAX);
      end else if (req_ch.gait_period_ms < PERIOD_IN_W'(PERIOD_MIN)) begin
         period_in = PERIOD_W'(PERIOD_MIN);
      end else begin
         period_in = req_ch.gait_period_ms[PERIOD_W-1:0];
      end
   end

   // gait step, taken when the tick word is accepted; the channels of this tick
   // see the old percentages, the wrap clears fired marks through the epoch bit
   always_comb begin
      gstep_inc = gstep_ff + 1'b1;
      gstep_due = (GPROD_W'(gstep_inc) * GPROD_W'(STEP_DIV)) >= GPROD_W'(period_in);
      gstep_in  = gstep_ff;
      pct_in    = pct_ff;
      epoch_in  = epoch_ff;
      for (int leg = 0; leg < LEGS; leg++) begin
         pct_plus[leg] = {1'b0, pct_ff[leg]} + 1'b1;
         pct_wrap[leg] = pct_plus[leg] > (PCT_W + 1)'(GAIT_STEPS);
      end
      if (accept) begin
         if (gstep_due) begin
            gstep_in = '0;
            for (int leg = 0; leg < LEGS; leg++) begin
               pct_in[leg]   = pct_wrap[leg] ? '0 : pct_plus[leg][PCT_W-1:0];
               epoch_in[leg] = epoch_ff[leg] ^ pct_wrap[leg];
            end
         end else begin
            gstep_in = gstep_inc;
         end
      end
      // right leg start point loads the right percentage at once
      if (csr_write_en && (csr_index_type'(csr_index) == CSR_RIGHT_START)) begin
         pct_in[LEG_RIGHT] = PCT_W'(csr_write_data[FP_W-1:0]);
      end
   end

   // channel issue sequencer
   always_comb begin
      iss_active_in = iss_active_ff;
      iss_idx_in    = iss_idx_ff;
      if (accept) begin
         iss_active_in = 1'b1;
         iss_idx_in    = CH_CALF;
      end else if (iss_active_ff) begin
         if (iss_idx_ff == CH_GLUTE) begin
            iss_active_in = 1'b0;
         end else begin
            iss_idx_in = iss_idx_ff + 1'b1;
         end
      end
   end

   // gait state, issue control and tick context
   always_ff @(posedge clock) begin
      if (reset) begin
         gstep_ff      <= '0;
         pct_ff        <= '0;
         epoch_ff      <= '0;
         iss_active_ff <= 1'b0;
         iss_idx_ff    <= CH_CALF;
      end else begin
         gstep_ff      <= gstep_in;
         pct_ff        <= pct_in;
         epoch_ff      <= epoch_in;
         iss_active_ff <= iss_active_in;
         iss_idx_ff    <= iss_idx_in;
      end
      if (accept) begin
         tick_ff.period <= period_in;
         tick_ff.pct    <= pct_ff;
         tick_ff.epoch  <= epoch_ff;
         for (int leg = 0; leg < LEGS; leg++) begin
            tick_ff.out_pct[leg] <= pct_in[leg][OUT_PCT_W-1:0];
         end
      end
   end

   // leg memories: read at issue, written back from the decide stage; a channel is
   // reissued only after its write-back, so accesses never overlap
   for (genvar g = 0; g < LEGS; g++) begin : g_leg
      gpvs_ram #(
         .WIDTH (CHAN_W),
         .DEPTH (LEG_CH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (s2_v_ff),
         .wr_addr (s2_idx_ff),
         .wr_data (wr_ent[g]),
         .rd_en   (iss_active_ff),
         .rd_addr (iss_idx_ff),
         .rd_data (rd_raw[g])
      );
   end

   // read stage: default unwritten entries, count up, scale elapsed, units times period
   always_comb begin
      chan_type ent;
      for (int leg = 0; leg < LEGS; leg++) begin
         ent = vld_ff[leg][s1_idx_ff] ? chan_type'(rd_raw[leg]) : RESET_ENT;
         s1_ent[leg] = ent;
         s1_ent[leg].elapsed = (ent.elapsed == '1) ? ent.elapsed : ent.elapsed + 1'b1;
         s1_ent[leg].fired   = ent.fired && (ent.epoch == s1_tick_ff.epoch[leg]);
         s1_prod[leg] = CMP_W'(s1_ent[leg].elapsed) * CMP_W'(STEP_DIV);
      end
      s1_up = PROD_UP_W'(units_ff[s1_idx_ff]) * PROD_UP_W'(s1_tick_ff.period);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= iss_active_ff;
         s2_v_ff <= s1_v_ff;
      end
      s1_idx_ff  <= iss_idx_ff;
      s1_tick_ff <= tick_ff;
      s2_idx_ff  <= s1_idx_ff;
      s2_tick_ff <= s1_tick_ff;
      s2_up_ff   <= s1_up;
      for (int leg = 0; leg < LEGS; leg++) begin
         s2_ent_ff[leg]  <= s1_ent[leg];
         s2_prod_ff[leg] <= s1_prod[leg];
      end
   end

   // decide stage: idle falls through to the contract and extend checks
   always_comb begin
      logic                   is_idle;
      logic                   is_contract;
      logic                   is_live;
      logic                   fire;
      logic                   rel;
      logic                   rearm;
      logic [TIMER_WIDTH-1:0] el1;
      logic [TIMER_WIDTH-1:0] el2;
      logic [CMP_W-1:0]       prod1;
      chan_type               ent;
      for (int leg = 0; leg < LEGS; leg++) begin
         ent         = s2_ent_ff[leg];
         is_idle     = 1'b0;
         is_contract = 1'b0;
         is_live     = 1'b0;
         case (ent.phase)
            PH_IDLE: begin
               is_idle = 1'b1;
               is_live = 1'b1;
            end
            PH_CONTRACT: begin
               is_contract = 1'b1;
               is_live     = 1'b1;
            end
            PH_EXTEND: begin
               is_live = 1'b1;
            end
            default: ;
         endcase
         fire  = is_idle && !ent.busy && !ent.fired &&
                 (s2_tick_ff.pct[leg] >= PCT_W'(fire_pt_ff[s2_idx_ff]));
         el1   = fire ? '0 : ent.elapsed;
         prod1 = fire ? '0 : s2_prod_ff[leg];
         rel   = (is_idle || is_contract) && (prod1 >= CMP_W'(s2_up_ff));
         el2   = rel ? '0 : el1;
         rearm = is_live && (el2 >= TIMER_WIDTH'(ext_delay_ff));

         wr_ent[leg]         = ent;
         wr_ent[leg].epoch   = s2_tick_ff.epoch[leg];
         wr_ent[leg].elapsed = el2;
         wr_ent[leg].fired   = ent.fired || fire;
         if (fire) begin
            wr_ent[leg].phase = PH_CONTRACT;
            wr_ent[leg].busy  = 1'b1;
         end
         if (rel) begin
            wr_ent[leg].phase = PH_EXTEND;
         end
         if (rearm) begin
            wr_ent[leg].phase = PH_IDLE;
            wr_ent[leg].busy  = 1'b0;
         end

         // release wins over fill in the same tick
         if (rel) begin
            cmd_w[leg] = CMD_RELEASE;
         end else if (fire) begin
            cmd_w[leg] = CMD_FILL;
         end else begin
            cmd_w[leg] = CMD_NONE;
         end
      end
   end

   // entry valid bits and command assembly
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (s2_v_ff) begin
         for (int leg = 0; leg < LEGS; leg++) begin
            vld_ff[leg][s2_idx_ff] <= 1'b1;
         end
      end
      if (s2_v_ff) begin
         for (int leg = 0; leg < LEGS; leg++) begin
            asm_ff[leg][s2_idx_ff] <= cmd_w[leg];
         end
      end
   end

   // result word is complete with the last channel of the tick
   assign push = s2_v_ff && (s2_idx_ff == CH_GLUTE);

   always_comb begin
      push_word.left_calf   = asm_ff[LEG_LEFT][CH_CALF];
      push_word.left_quad   = asm_ff[LEG_LEFT][CH_QUAD];
      push_word.left_glute  = cmd_w[LEG_LEFT];
      push_word.right_calf  = asm_ff[LEG_RIGHT][CH_CALF];
      push_word.right_quad  = asm_ff[LEG_RIGHT][CH_QUAD];
      push_word.right_glute = cmd_w[LEG_RIGHT];
      push_word.left_pct    = s2_tick_ff.out_pct[LEG_LEFT];
      push_word.right_pct   = s2_tick_ff.out_pct[LEG_RIGHT];
   end

   // output register with one skid slot
   always_comb begin
      out_in    = out_ff;
      skid_in   = skid_ff;
      out_v_in  = out_v_ff;
      skid_v_in = skid_v_ff;
      case ({push, pop})
         2'b10: begin
            if (!out_v_ff) begin
               out_in   = push_word;
               out_v_in = 1'b1;
            end else begin
               skid_in   = push_word;
               skid_v_in = 1'b1;
            end
         end
         2'b01: begin
            if (skid_v_ff) begin
               out_in    = skid_ff;
               skid_v_in = 1'b0;
            end else begin
               out_v_in = 1'b0;
            end
         end
         2'b11: begin
            if (skid_v_ff) begin
               out_in  = skid_ff;
               skid_in = push_word;
            end else begin
               out_in = push_word;
            end
         end
         default: ;
      endcase
      occ_in = occ_ff + OCC_W'(accept) - OCC_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
         occ_ff    <= '0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
         occ_ff    <= occ_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_ch.valid           = out_v_ff;
   assign rsp_ch.left_calf_cmd   = out_ff.left_calf;
   assign rsp_ch.left_quad_cmd   = out_ff.left_quad;
   assign rsp_ch.left_glute_cmd  = out_ff.left_glute;
   assign rsp_ch.right_calf_cmd  = out_ff.right_calf;
   assign rsp_ch.right_quad_cmd  = out_ff.right_quad;
   assign rsp_ch.right_glute_cmd = out_ff.right_glute;
   assign rsp_ch.left_gait_pct   = out_ff.left_pct;
   assign rsp_ch.right_gait_pct  = out_ff.right_pct;

   // write-back never hits the entry being read in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(s2_v_ff && iss_active_ff && (s2_idx_ff == iss_idx_ff)))
      else $error("leg memory read and write-back collide on one entry");

   // a finished word always finds a free output slot
   a_no_slot_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !(out_v_ff && skid_v_ff && !pop))
      else $error("result word pushed with both output slots full");

   // an accepted tick reaches the decide stage with its first channel, via issue and read
   a_tick_timing: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 (s2_v_ff && (s2_idx_ff == CH_CALF)))
      else $error("accepted tick did not reach the decide stage on time");

   // a shown result is always counted as outstanding
   a_occ_tracks_out: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (occ_ff != '0))
      else $error("result valid with no outstanding tick counted");

endmodule
